### sv/vertex_rotate_translate_project_macros.svh
// Assertion helpers for the vertex projection pipeline
`ifndef VERTEX_ROTATE_TRANSLATE_PROJECT_MACROS_SVH
`define VERTEX_ROTATE_TRANSLATE_PROJECT_MACROS_SVH

// condition holds at every edge out of reset
`define VRTP_ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("vrtp invariant violated");

// antecedent implies consequent at the same edge
`define VRTP_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("vrtp implication violated");

// antecedent implies consequent a fixed number of edges later
`define VRTP_ASSERT_DELAY(lbl, clk, rst, ante, n, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
      else $error("vrtp latency violated");

`endif

### sv/vrtp_pkg.sv
`timescale 1ns / 1ps
package vrtp_pkg;

   localparam int FRAC_BITS = 8;
   localparam int TRIG_FRAC = 14;
   localparam int CRD_W     = 24;
   localparam int TRIG_W    = 16;
   localparam int DIST_W    = 10;
   localparam int SIZE_W    = 12;
   localparam int SCR_W     = 16;
   localparam int PROD_W    = CRD_W + TRIG_W;
   localparam int RW        = PROD_W - TRIG_FRAC + 2;
   localparam int NW        = RW + DIST_W;
   localparam int DIV_BITS  = 18;
   localparam int SUM_W     = DIV_BITS + 2;
   localparam int LATENCY   = DIV_BITS + 6;

   localparam logic signed [SCR_W-1:0] HIDDEN_COORD = -16'sd666;
   localparam logic signed [RW-1:0]    Z_MIN        = RW'(2 << FRAC_BITS);

   localparam logic [2:0] REG_COS    = 3'd0;
   localparam logic [2:0] REG_SIN    = 3'd1;
   localparam logic [2:0] REG_CAM_X  = 3'd2;
   localparam logic [2:0] REG_CAM_Y  = 3'd3;
   localparam logic [2:0] REG_CAM_Z  = 3'd4;
   localparam logic [2:0] REG_DIST   = 3'd5;
   localparam logic [2:0] REG_WIDTH  = 3'd6;
   localparam logic [2:0] REG_HEIGHT = 3'd7;

   typedef struct packed {
      logic signed [CRD_W-1:0] vertex_x;
      logic signed [CRD_W-1:0] vertex_y;
      logic signed [CRD_W-1:0] vertex_z;
      logic                    last_vertex;
   } req_type;

   typedef struct packed {
      logic signed [SCR_W-1:0] screen_x;
      logic signed [SCR_W-1:0] screen_y;
      logic                    visible;
      logic                    last_out;
   } rsp_type;

   typedef struct packed {
      logic valid;
      logic vis;
      logic last;
   } ctl_type;

   typedef struct packed {
      logic signed [TRIG_W-1:0] cos_angle;
      logic signed [TRIG_W-1:0] sin_angle;
      logic signed [CRD_W-1:0]  cam_x;
      logic signed [CRD_W-1:0]  cam_y;
      logic signed [CRD_W-1:0]  cam_z;
      logic [DIST_W-1:0]        view_distance;
      logic [SIZE_W-1:0]        screen_width;
      logic [SIZE_W-1:0]        screen_height;
   } cfg_type;

   function automatic logic signed [SCR_W-1:0] sat16(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] hi;
      logic signed [SUM_W-1:0] lo;
      hi = SUM_W'(32767);
      lo = -SUM_W'(32768);
      if (v > hi) begin
         return 16'sh7fff;
      end else if (v < lo) begin
         return 16'sh8000;
      end
      return v[SCR_W-1:0];
   endfunction

endpackage

### sv/vrtp_rotate.sv
`timescale 1ns / 1ps
module vrtp_rotate (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  vrtp_pkg::req_type             in_data,
   input  vrtp_pkg::cfg_type             cfg,
   output vrtp_pkg::ctl_type             out_ctl,
   output logic signed [vrtp_pkg::RW-1:0] out_rx,
   output logic signed [vrtp_pkg::RW-1:0] out_ry,
   output logic signed [vrtp_pkg::RW-1:0] out_rz
);
   import vrtp_pkg::*;

   ctl_type                  ctl_a_ff, ctl_b_ff;
   logic signed [PROD_W-1:0] xc_ff, zs_ff, xs_ff, zc_ff;
   logic signed [PROD_W-1:0] xc_in, zs_in, xs_in, zc_in;
   logic signed [RW-1:0]     ry_a_ff, ry_a_in;
   logic signed [RW-1:0]     rx_ff, ry_ff, rz_ff, rx_in, rz_in;

   assign xc_in   = in_data.vertex_x * cfg.cos_angle;
   assign zs_in   = in_data.vertex_z * cfg.sin_angle;
   assign xs_in   = in_data.vertex_x * cfg.sin_angle;
   assign zc_in   = in_data.vertex_z * cfg.cos_angle;
   assign ry_a_in = RW'(in_data.vertex_y) + RW'(cfg.cam_y);

   assign rx_in = RW'(xc_ff >>> TRIG_FRAC) - RW'(zs_ff >>> TRIG_FRAC) + RW'(cfg.cam_x);
   assign rz_in = RW'(xs_ff >>> TRIG_FRAC) + RW'(zc_ff >>> TRIG_FRAC) + RW'(cfg.cam_z);

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_a_ff <= '0;
         ctl_b_ff <= '0;
      end else begin
         ctl_a_ff.valid <= in_valid;
         ctl_a_ff.vis   <= 1'b0;
         ctl_a_ff.last  <= in_data.last_vertex;
         ctl_b_ff.valid <= ctl_a_ff.valid;
         ctl_b_ff.vis   <= rz_in > Z_MIN;
         ctl_b_ff.last  <= ctl_a_ff.last;
      end
   end

   always_ff @(posedge clock) begin
      xc_ff   <= xc_in;
      zs_ff   <= zs_in;
      xs_ff   <= xs_in;
      zc_ff   <= zc_in;
      ry_a_ff <= ry_a_in;
      rx_ff   <= rx_in;
      ry_ff   <= ry_a_ff;
      rz_ff   <= rz_in;
   end

   assign out_ctl = ctl_b_ff;
   assign out_rx  = rx_ff;
   assign out_ry  = ry_ff;
   assign out_rz  = rz_ff;

endmodule

### sv/vrtp_div.sv
`timescale 1ns / 1ps
module vrtp_div (
   input  logic                            clock,
   input  logic                            reset,
   input  vrtp_pkg::ctl_type               in_ctl,
   input  logic signed [vrtp_pkg::NW-1:0]  in_num,
   input  logic [vrtp_pkg::RW-1:0]         in_den,
   output vrtp_pkg::ctl_type               out_ctl,
   output logic [vrtp_pkg::DIV_BITS-1:0]   out_mag,
   output logic                            out_neg
);
   import vrtp_pkg::*;

   localparam int CW = NW + DIV_BITS;

   ctl_type               ctl_ff [DIV_BITS+1];
   logic [NW-1:0]         rem_ff [DIV_BITS+1];
   logic [RW-1:0]         den_ff [DIV_BITS+1];
   logic [DIV_BITS-1:0]   quo_ff [DIV_BITS+1];
   logic                  neg_ff [DIV_BITS+1];
   logic                  ovf_ff [DIV_BITS+1];
   logic [NW-1:0]         mag_in;
   logic                  ovf_in;

   assign mag_in = in_num[NW-1] ? NW'(-in_num) : NW'(in_num);
   assign ovf_in = CW'(mag_in) >= (CW'(in_den) << DIV_BITS);

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff[0] <= '0;
      end else begin
         ctl_ff[0] <= in_ctl;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff[0] <= mag_in;
      den_ff[0] <= in_den;
      quo_ff[0] <= '0;
      neg_ff[0] <= in_num[NW-1];
      ovf_ff[0] <= ovf_in;
   end

   for (genvar j = 1; j <= DIV_BITS; j++) begin : g_step
      localparam int K = DIV_BITS - j;
      logic [CW-1:0]       trial;
      logic                fit;
      logic [NW-1:0]       rem_in;
      logic [DIV_BITS-1:0] quo_in;

      assign trial  = CW'(den_ff[j-1]) << K;
      assign fit    = CW'(rem_ff[j-1]) >= trial;
      assign rem_in = fit ? rem_ff[j-1] - trial[NW-1:0] : rem_ff[j-1];
      always_comb begin
         quo_in    = quo_ff[j-1];
         quo_in[K] = fit;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[j] <= '0;
         end else begin
            ctl_ff[j] <= ctl_ff[j-1];
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[j] <= rem_in;
         den_ff[j] <= den_ff[j-1];
         quo_ff[j] <= quo_in;
         neg_ff[j] <= neg_ff[j-1];
         ovf_ff[j] <= ovf_ff[j-1];
      end
   end

   assign out_ctl = ctl_ff[DIV_BITS];
   assign out_mag = ovf_ff[DIV_BITS] ? '1 : quo_ff[DIV_BITS];
   assign out_neg = neg_ff[DIV_BITS];

endmodule

### sv/vertex_rotate_translate_project.sv
// Throughput: one vertex per cycle; busy stays low, the pipeline never stalls.
// The depth is set by two 18-stage restoring dividers, one quotient bit per stage.
// Reset (sync, active high) clears the control bits and loads register defaults.
`timescale 1ns / 1ps
module vertex_rotate_translate_project (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  vrtp_pkg::req_type     req_data,
   output logic                  rsp_strobe,
   output vrtp_pkg::rsp_type     rsp_data,
   input  logic                  csr_we,
   input  logic [2:0]            csr_index,
   input  logic [23:0]           csr_wdata
);
   import vrtp_pkg::*;
`include "vertex_rotate_translate_project_macros.svh"

   cfg_type              cfg_ff;
   logic                 in_valid_ff;
   req_type              in_data_ff;
   ctl_type              rot_ctl, mul_ctl_ff, ctl_x, ctl_y;
   logic signed [RW-1:0] rx, ry, rz, rz_ff;
   logic signed [NW:0]   prod_x, prod_y;
   logic signed [NW-1:0] nx_ff, ny_ff;
   logic [DIV_BITS-1:0]  mag_x, mag_y;
   logic                 neg_x, neg_y;
   logic signed [SUM_W-1:0] sum_x, sum_y;
   logic                 rsp_strobe_ff;
   rsp_type              rsp_data_ff, rsp_data_in;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cos_angle     <= 16'sd16384;
         cfg_ff.sin_angle     <= '0;
         cfg_ff.cam_x         <= '0;
         cfg_ff.cam_y         <= '0;
         cfg_ff.cam_z         <= '0;
         cfg_ff.view_distance <= 10'd256;
         cfg_ff.screen_width  <= 12'd640;
         cfg_ff.screen_height <= 12'd480;
      end else if (csr_we) begin
         case (csr_index)
            REG_COS:    cfg_ff.cos_angle     <= csr_wdata[TRIG_W-1:0];
            REG_SIN:    cfg_ff.sin_angle     <= csr_wdata[TRIG_W-1:0];
            REG_CAM_X:  cfg_ff.cam_x         <= csr_wdata;
            REG_CAM_Y:  cfg_ff.cam_y         <= csr_wdata;
            REG_CAM_Z:  cfg_ff.cam_z         <= csr_wdata;
            REG_DIST:   cfg_ff.view_distance <= csr_wdata[DIST_W-1:0];
            REG_WIDTH:  cfg_ff.screen_width  <= csr_wdata[SIZE_W-1:0];
            REG_HEIGHT: cfg_ff.screen_height <= csr_wdata[SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff <= req_data;
   end

   vrtp_rotate u_rotate (
      .clock    (clock),
      .reset    (reset),
      .in_valid (in_valid_ff),
      .in_data  (in_data_ff),
      .cfg      (cfg_ff),
      .out_ctl  (rot_ctl),
      .out_rx   (rx),
      .out_ry   (ry),
      .out_rz   (rz)
   );

   assign prod_x = $signed({1'b0, cfg_ff.view_distance}) * rx;
   assign prod_y = $signed({1'b0, cfg_ff.view_distance}) * ry;

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_ctl_ff <= '0;
      end else begin
         mul_ctl_ff <= rot_ctl;
      end
   end

   always_ff @(posedge clock) begin
      nx_ff <= prod_x[NW-1:0];
      ny_ff <= prod_y[NW-1:0];
      rz_ff <= rz;
   end

   vrtp_div u_div_x (
      .clock   (clock),
      .reset   (reset),
      .in_ctl  (mul_ctl_ff),
      .in_num  (nx_ff),
      .in_den  (rz_ff),
      .out_ctl (ctl_x),
      .out_mag (mag_x),
      .out_neg (neg_x)
   );

   vrtp_div u_div_y (
      .clock   (clock),
      .reset   (reset),
      .in_ctl  (mul_ctl_ff),
      .in_num  (ny_ff),
      .in_den  (rz_ff),
      .out_ctl (ctl_y),
      .out_mag (mag_y),
      .out_neg (neg_y)
   );

   assign sum_x = (neg_x ? -SUM_W'(mag_x) : SUM_W'(mag_x))
                + SUM_W'(cfg_ff.screen_width[SIZE_W-1:1]);
   assign sum_y = (neg_y ? SUM_W'(mag_y) : -SUM_W'(mag_y))
                + SUM_W'(cfg_ff.screen_height[SIZE_W-1:1]);

   always_comb begin
      rsp_data_in.visible  = ctl_x.vis;
      rsp_data_in.last_out = ctl_x.last;
      if (ctl_x.vis) begin
         rsp_data_in.screen_x = sat16(sum_x);
         rsp_data_in.screen_y = sat16(sum_y);
      end else begin
         rsp_data_in.screen_x = HIDDEN_COORD;
         rsp_data_in.screen_y = HIDDEN_COORD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= ctl_x.valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   `VRTP_ASSERT_ALWAYS(a_div_lockstep, clock, reset, ctl_x == ctl_y)
   `VRTP_ASSERT_IMPLY(a_hidden_coord, clock, reset, rsp_strobe && !rsp_data.visible,
      rsp_data.screen_x == HIDDEN_COORD && rsp_data.screen_y == HIDDEN_COORD)
   `VRTP_ASSERT_DELAY(a_latency, clock, reset, start && !busy, 24, rsp_strobe)

endmodule
